@@ sv/rtsfme_pkg.sv @@
// ----------------------------------------------------------------------------
// rtsfme_pkg
// Shared types and constants of the rolling-code frame encoder.
// ----------------------------------------------------------------------------
package rtsfme_pkg;

    // Frame geometry
    localparam int FRAME_BYTES = 7;
    localparam int FRAME_BITS  = FRAME_BYTES * 8;
    localparam int CNT_W       = 6;
    localparam logic [CNT_W-1:0] FRAME_LAST = CNT_W'(FRAME_BITS - 1);

    // Sync count limits
    localparam int SYNC_MIN = 1;
    localparam int SYNC_MAX = 7;

    // Symbol kinds on the output channel
    localparam logic [1:0] KIND_HW_SYNC = 2'd0;
    localparam logic [1:0] KIND_SW_SYNC = 2'd1;
    localparam logic [1:0] KIND_DATA    = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] CFG_KEY_BYTE = 3'd0;
    localparam logic [2:0] CFG_HW_HIGH  = 3'd1;
    localparam logic [2:0] CFG_HW_LOW   = 3'd2;
    localparam logic [2:0] CFG_SW_HIGH  = 3'd3;
    localparam logic [2:0] CFG_SW_LOW   = 3'd4;
    localparam logic [2:0] CFG_SYMBOL   = 3'd5;

    // Register reset values
    localparam logic [7:0]  RST_KEY_BYTE = 8'hA7;
    localparam logic [15:0] RST_HW_HIGH  = 16'd2416;
    localparam logic [15:0] RST_HW_LOW   = 16'd2416;
    localparam logic [15:0] RST_SW_HIGH  = 16'd4550;
    localparam logic [15:0] RST_SW_LOW   = 16'd640;
    localparam logic [15:0] RST_SYMBOL   = 16'd1280;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HW_SYNC,
        ST_SW_SYNC,
        ST_DATA
    } t_state;

    // Control from the sequencer to the frame shifter
    typedef struct packed {
        logic load;
        logic shift;
    } t_shift_ctrl;

endpackage

@@ sv/rtsfme_cmd_if.sv @@
// ----------------------------------------------------------------------------
// rtsfme_cmd_if
// Command channel: one transfer carries one frame request.
// ----------------------------------------------------------------------------
interface rtsfme_cmd_if;
    logic        valid;
    logic        ready;
    logic [3:0]  cmd_code;
    logic [23:0] remote_addr;
    logic [15:0] roll_count;
    logic        short_sync;

    modport source (
        output valid, cmd_code, remote_addr, roll_count, short_sync,
        input  ready
    );
    modport sink (
        input  valid, cmd_code, remote_addr, roll_count, short_sync,
        output ready
    );
endinterface

@@ sv/rtsfme_sym_if.sv @@
// ----------------------------------------------------------------------------
// rtsfme_sym_if
// Symbol channel: one transfer carries one pulse description.
// ----------------------------------------------------------------------------
interface rtsfme_sym_if;
    logic        valid;
    logic        ready;
    logic [1:0]  symbol_kind;
    logic        bit_value;
    logic        mark_first;
    logic [15:0] first_us;
    logic [15:0] second_us;
    logic        last_symbol;

    modport source (
        output valid, symbol_kind, bit_value, mark_first, first_us, second_us,
               last_symbol,
        input  ready
    );
    modport sink (
        input  valid, symbol_kind, bit_value, mark_first, first_us, second_us,
               last_symbol,
        output ready
    );
endinterface

@@ sv/rts_frame_manchester_encoder_unit.sv @@
// ----------------------------------------------------------------------------
// rts_frame_manchester_encoder_unit
// Rolling-code radio frame encoder with Manchester pulse output.
// ----------------------------------------------------------------------------
// Each accepted command produces its hardware sync pulses (FULL_SYNC_COUNT,
// or SHORT_SYNC_COUNT when short_sync is set, held to 1..7), one software
// sync pulse and 56 Manchester data symbols, one symbol per cycle while the
// output side takes them. The command transfer happens in the idle state.
// The frame shift register moves one bit per data symbol, and the sequencer
// takes a new command once the final symbol of the current one sits in the
// output register. Configuration writes are to be made by the user only
// while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module rts_frame_manchester_encoder_unit
    import rtsfme_pkg::*;
#(
    parameter int FULL_SYNC_COUNT  = 7,
    parameter int SHORT_SYNC_COUNT = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wr_en,
    input  logic [2:0]   i_cfg_index,
    input  logic [15:0]  i_cfg_data,
    rtsfme_cmd_if.sink   i_cmd,
    rtsfme_sym_if.source o_sym
);

    // Sync counts held to the legal range
    localparam int FULL_N  = (FULL_SYNC_COUNT < SYNC_MIN) ? SYNC_MIN :
                             (FULL_SYNC_COUNT > SYNC_MAX) ? SYNC_MAX : FULL_SYNC_COUNT;
    localparam int SHORT_N = (SHORT_SYNC_COUNT < SYNC_MIN) ? SYNC_MIN :
                             (SHORT_SYNC_COUNT > SYNC_MAX) ? SYNC_MAX : SHORT_SYNC_COUNT;

    // Configuration registers
    logic [7:0]  r_key_byte;
    logic [15:0] r_hw_high;
    logic [15:0] r_hw_low;
    logic [15:0] r_sw_high;
    logic [15:0] r_sw_low;
    logic [15:0] r_symbol;

    // Sequencer
    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    // Output register
    logic        r_out_valid, n_out_valid;
    logic [1:0]  r_kind, n_kind;
    logic        r_bit, n_bit;
    logic        r_mark, n_mark;
    logic [15:0] r_first, n_first;
    logic [15:0] r_second, n_second;
    logic        r_last, n_last;

    logic        advance;
    logic        cmd_xfer;
    logic        emit;
    logic        data_bit;
    logic [15:0] half_us;
    t_shift_ctrl shift_ctrl;

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_byte <= RST_KEY_BYTE;
            r_hw_high  <= RST_HW_HIGH;
            r_hw_low   <= RST_HW_LOW;
            r_sw_high  <= RST_SW_HIGH;
            r_sw_low   <= RST_SW_LOW;
            r_symbol   <= RST_SYMBOL;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_KEY_BYTE: r_key_byte <= i_cfg_data[7:0];
                CFG_HW_HIGH:  r_hw_high  <= i_cfg_data;
                CFG_HW_LOW:   r_hw_low   <= i_cfg_data;
                CFG_SW_HIGH:  r_sw_high  <= i_cfg_data;
                CFG_SW_LOW:   r_sw_low   <= i_cfg_data;
                CFG_SYMBOL:   r_symbol   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Frame shift register
    rtsfme_frame_shift u_shift (
        .i_clk  (i_clk),
        .i_ctrl (shift_ctrl),
        .i_key  (r_key_byte),
        .i_code (i_cmd.cmd_code),
        .i_chan (i_cmd.remote_addr),
        .i_roll (i_cmd.roll_count),
        .o_bit  (data_bit)
    );

    assign half_us     = {1'b0, r_symbol[15:1]};
    assign advance     = !r_out_valid || o_sym.ready;
    assign i_cmd.ready = (r_state == ST_IDLE);
    assign cmd_xfer    = i_cmd.valid && i_cmd.ready;

    // Next state and symbol generation
    always_comb begin
        n_state          = r_state;
        n_cnt            = r_cnt;
        emit             = 1'b0;
        n_kind           = r_kind;
        n_bit            = r_bit;
        n_mark           = r_mark;
        n_first          = r_first;
        n_second         = r_second;
        n_last           = r_last;
        shift_ctrl.load  = 1'b0;
        shift_ctrl.shift = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (cmd_xfer) begin
                    shift_ctrl.load = 1'b1;
                    n_cnt   = i_cmd.short_sync ? CNT_W'(SHORT_N) : CNT_W'(FULL_N);
                    n_state = ST_HW_SYNC;
                end
            end
            ST_HW_SYNC: begin
                if (advance) begin
                    emit     = 1'b1;
                    n_kind   = KIND_HW_SYNC;
                    n_bit    = 1'b0;
                    n_mark   = 1'b1;
                    n_first  = r_hw_high;
                    n_second = r_hw_low;
                    n_last   = 1'b0;
                    if (r_cnt == CNT_W'(1)) begin
                        n_cnt   = FRAME_LAST;
                        n_state = ST_SW_SYNC;
                    end else begin
                        n_cnt = r_cnt - CNT_W'(1);
                    end
                end
            end
            ST_SW_SYNC: begin
                if (advance) begin
                    emit     = 1'b1;
                    n_kind   = KIND_SW_SYNC;
                    n_bit    = 1'b0;
                    n_mark   = 1'b1;
                    n_first  = r_sw_high;
                    n_second = r_sw_low;
                    n_last   = 1'b0;
                    n_state  = ST_DATA;
                end
            end
            ST_DATA: begin
                if (advance) begin
                    emit             = 1'b1;
                    shift_ctrl.shift = 1'b1;
                    n_kind           = KIND_DATA;
                    n_bit            = data_bit;
                    n_mark           = !data_bit;
                    n_first          = half_us;
                    n_second         = half_us;
                    n_last           = (r_cnt == '0);
                    n_cnt            = r_cnt - CNT_W'(1);
                    if (r_cnt == '0) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
        n_out_valid = advance ? emit : r_out_valid;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        r_kind   <= n_kind;
        r_bit    <= n_bit;
        r_mark   <= n_mark;
        r_first  <= n_first;
        r_second <= n_second;
        r_last   <= n_last;
    end

    assign o_sym.valid       = r_out_valid;
    assign o_sym.symbol_kind = r_kind;
    assign o_sym.bit_value   = r_bit;
    assign o_sym.mark_first  = r_mark;
    assign o_sym.first_us    = r_first;
    assign o_sym.second_us   = r_second;
    assign o_sym.last_symbol = r_last;

    // Checks
    a_last_is_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_sym.valid && o_sym.last_symbol |-> o_sym.symbol_kind == KIND_DATA)
        else $error("last_symbol on a sync pulse");

    a_manchester: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_sym.valid && o_sym.symbol_kind == KIND_DATA |->
            o_sym.mark_first != o_sym.bit_value)
        else $error("data symbol phase order does not match bit value");

    a_sw_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_SW_SYNC |-> r_cnt == FRAME_LAST)
        else $error("data bit counter not primed at software sync");

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.valid && i_cmd.ready |=> !i_cmd.ready)
        else $error("command taken while a frame is in progress");

endmodule

@@ sv/rtsfme_frame_shift.sv @@
// ----------------------------------------------------------------------------
// rtsfme_frame_shift
// Holds the plain frame and sends it out one bit per shift, applying the
// byte-chained XOR obfuscation on the fly.
// ----------------------------------------------------------------------------
module rtsfme_frame_shift
    import rtsfme_pkg::*;
(
    input  logic        i_clk,
    input  t_shift_ctrl i_ctrl,
    input  logic [7:0]  i_key,
    input  logic [3:0]  i_code,
    input  logic [23:0] i_chan,
    input  logic [15:0] i_roll,
    output logic        o_bit
);

    logic [FRAME_BITS-1:0] r_raw;
    logic [7:0]            r_prev;
    logic [3:0]            csum;

    // XOR of every nibble, checksum slot taken as zero
    assign csum = i_key[7:4] ^ i_key[3:0] ^ i_code
                ^ i_roll[15:12] ^ i_roll[11:8] ^ i_roll[7:4] ^ i_roll[3:0]
                ^ i_chan[23:20] ^ i_chan[19:16] ^ i_chan[15:12]
                ^ i_chan[11:8] ^ i_chan[7:4] ^ i_chan[3:0];

    // Obfuscated bit: plain bit XOR same bit of previous obfuscated byte
    assign o_bit = r_raw[FRAME_BITS-1] ^ r_prev[7];

    // r_prev rotates the previous byte so its matching bit sits at the top
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_raw  <= {i_key, i_code, csum, i_roll[15:8], i_roll[7:0],
                       i_chan[7:0], i_chan[15:8], i_chan[23:16]};
            r_prev <= 8'h00;
        end else if (i_ctrl.shift) begin
            r_raw  <= {r_raw[FRAME_BITS-2:0], 1'b0};
            r_prev <= {r_prev[6:0], o_bit};
        end
    end

endmodule

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the rolling-code frame encoder.
// ----------------------------------------------------------------------------
// Commands go in over the command channel and every pulse that comes back is
// compared, field by field, with a pulse list built here from the register
// mirror: frame assembly, nibble checksum, byte chaining, sync burst and
// Manchester data bits. Both channels idle and stall at random, except in
// one steady stretch. Registers are rewritten between phases while idle.
// ----------------------------------------------------------------------------
module testbench
    import rtsfme_pkg::*;
();

    localparam int FULL_SYNCS  = 7;
    localparam int SHORT_SYNCS = 2;

    // Indexes past the register list: writes there must change nothing
    localparam logic [2:0] CFG_SPARE_LO = 3'd6;
    localparam logic [2:0] CFG_SPARE_HI = 3'd7;

    localparam int IDLE_PCT      = 27;
    localparam int SETTLE_CYCLES = 80;
    localparam int CYCLE_LIMIT   = 600000;

    typedef struct packed {
        logic [3:0]  cmd_code;
        logic [23:0] remote_addr;
        logic [15:0] roll_count;
        logic        short_sync;
    } t_command;

    typedef struct packed {
        logic [1:0]  kind;
        logic        bit_value;
        logic        mark_first;
        logic [15:0] first_us;
        logic [15:0] second_us;
        logic        last_symbol;
    } t_pulse;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [2:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    rtsfme_cmd_if cmd_ch ();
    rtsfme_sym_if sym_ch ();

    rts_frame_manchester_encoder_unit #(
        .FULL_SYNC_COUNT  (FULL_SYNCS),
        .SHORT_SYNC_COUNT (SHORT_SYNCS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd_ch),
        .o_sym       (sym_ch)
    );

    // Register mirror
    logic [7:0]  cfg_key;
    logic [15:0] cfg_hw_high;
    logic [15:0] cfg_hw_low;
    logic [15:0] cfg_sw_high;
    logic [15:0] cfg_sw_low;
    logic [15:0] cfg_symbol;

    t_pulse awaited_pulses [$];

    bit sender_idles = 1'b1;
    bit receiver_stalls = 1'b1;
    int error_count;
    int commands_sent;
    int short_frames;
    int pulses_checked;
    int register_writes;
    int cycle_count;

    t_pulse seen_pulse;
    t_pulse want_pulse;

    // Clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d pulses still awaited",
                     cycle_count, awaited_pulses.size());
            $display("status: fail");
            $finish;
        end
    end

    // Receiver back-pressure
    always @(posedge i_clk) begin
        sym_ch.ready <= !receiver_stalls || ($urandom_range(99) >= IDLE_PCT);
    end

    // Builds the pulses one command produces under the current registers
    function automatic void encode_frame_pulses(input t_command c);
        logic [7:0]  frame [0:FRAME_BYTES-1];
        logic [7:0]  sum;
        logic [7:0]  chain;
        logic [15:0] half;
        logic        b;
        int          n_sync;
        frame[0] = cfg_key;
        frame[1] = {c.cmd_code, 4'h0};
        frame[2] = c.roll_count[15:8];
        frame[3] = c.roll_count[7:0];
        frame[4] = c.remote_addr[7:0];
        frame[5] = c.remote_addr[15:8];
        frame[6] = c.remote_addr[23:16];
        // checksum over all nibbles, with its own nibble still zero
        sum = 8'h00;
        for (int i = 0; i < FRAME_BYTES; i++)
            sum = sum ^ frame[i] ^ (frame[i] >> 4);
        frame[1][3:0] = sum[3:0];
        // each byte chained with the previous chained byte
        chain = 8'h00;
        for (int i = 0; i < FRAME_BYTES; i++) begin
            frame[i] = frame[i] ^ chain;
            chain    = frame[i];
        end
        n_sync = c.short_sync ? SHORT_SYNCS : FULL_SYNCS;
        if (n_sync < SYNC_MIN) n_sync = SYNC_MIN;
        if (n_sync > SYNC_MAX) n_sync = SYNC_MAX;
        for (int i = 0; i < n_sync; i++)
            awaited_pulses.push_back('{KIND_HW_SYNC, 1'b0, 1'b1, cfg_hw_high,
                                       cfg_hw_low, 1'b0});
        awaited_pulses.push_back('{KIND_SW_SYNC, 1'b0, 1'b1, cfg_sw_high,
                                   cfg_sw_low, 1'b0});
        half = cfg_symbol >> 1;
        for (int i = 0; i < FRAME_BYTES; i++) begin
            for (int j = 7; j >= 0; j--) begin
                b = frame[i][j];
                awaited_pulses.push_back('{KIND_DATA, b, !b, half, half,
                                           (i == FRAME_BYTES - 1) && (j == 0)});
            end
        end
    endfunction

    function automatic void compare_field(input string field, input logic [15:0] want,
                                          input logic [15:0] got);
        if (got !== want) begin
            error_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, field, want, got);
        end
    endfunction

    // Pulse checker
    always @(posedge i_clk) begin
        if (i_rst_n && sym_ch.valid && sym_ch.ready) begin
            seen_pulse = '{sym_ch.symbol_kind, sym_ch.bit_value, sym_ch.mark_first,
                           sym_ch.first_us, sym_ch.second_us, sym_ch.last_symbol};
            if (awaited_pulses.size() == 0) begin
                error_count++;
                $display("%0t: unexpected pulse, expected none, actual %h",
                         $time, seen_pulse);
            end else begin
                want_pulse = awaited_pulses.pop_front();
                compare_field("symbol_kind", 16'(want_pulse.kind), 16'(seen_pulse.kind));
                compare_field("bit_value", 16'(want_pulse.bit_value),
                              16'(seen_pulse.bit_value));
                compare_field("mark_first", 16'(want_pulse.mark_first),
                              16'(seen_pulse.mark_first));
                compare_field("first_us", want_pulse.first_us, seen_pulse.first_us);
                compare_field("second_us", want_pulse.second_us, seen_pulse.second_us);
                compare_field("last_symbol", 16'(want_pulse.last_symbol),
                              16'(seen_pulse.last_symbol));
                pulses_checked++;
            end
        end
    end

    // One command transfer; valid stays high afterwards for back-to-back use
    task automatic send_command(input t_command c);
        while (sender_idles && ($urandom_range(99) < IDLE_PCT)) begin
            cmd_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_ch.valid       <= 1'b1;
        cmd_ch.cmd_code    <= c.cmd_code;
        cmd_ch.remote_addr <= c.remote_addr;
        cmd_ch.roll_count  <= c.roll_count;
        cmd_ch.short_sync  <= c.short_sync;
        @(posedge i_clk);
        while (!cmd_ch.ready) @(posedge i_clk);
        encode_frame_pulses(c);
        commands_sent++;
        if (c.short_sync) short_frames++;
    endtask

    function automatic t_command random_command();
        t_command c;
        c.cmd_code    = 4'($urandom);
        c.remote_addr = 24'($urandom);
        c.roll_count  = 16'($urandom);
        c.short_sync  = 1'($urandom);
        return c;
    endfunction

    // Stop sending and wait for every awaited pulse, then let the block settle
    task automatic drain_pulses();
        cmd_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (awaited_pulses.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [2:0] index, input logic [15:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (index)
            CFG_KEY_BYTE: cfg_key     = data[7:0];
            CFG_HW_HIGH:  cfg_hw_high = data;
            CFG_HW_LOW:   cfg_hw_low  = data;
            CFG_SW_HIGH:  cfg_sw_high = data;
            CFG_SW_LOW:   cfg_sw_low  = data;
            CFG_SYMBOL:   cfg_symbol  = data;
            default: ;
        endcase
        register_writes++;
        @(posedge i_clk);
    endtask

    task automatic write_all_registers(input logic [15:0] key, hw_hi, hw_lo,
                                       sw_hi, sw_lo, symbol);
        write_register(CFG_KEY_BYTE, key);
        write_register(CFG_HW_HIGH, hw_hi);
        write_register(CFG_HW_LOW, hw_lo);
        write_register(CFG_SW_HIGH, sw_hi);
        write_register(CFG_SW_LOW, sw_lo);
        write_register(CFG_SYMBOL, symbol);
    endtask

    // Reset values with field extremes and both sync lengths
    task automatic test_reset_defaults();
        send_command('{4'h0, 24'h000000, 16'h0000, 1'b0});
        send_command('{4'hF, 24'hFFFFFF, 16'hFFFF, 1'b1});
        send_command('{4'hF, 24'h000000, 16'hFFFF, 1'b0});
        send_command('{4'h0, 24'hFFFFFF, 16'h0000, 1'b1});
        send_command('{4'hA, 24'h5A5A5A, 16'hA5A5, 1'b0});
        send_command('{4'h5, 24'hA5A5A5, 16'h5A5A, 1'b1});
        drain_pulses();
    endtask

    // All registers at zero, at full scale, and odd symbol periods
    task automatic test_register_extremes();
        write_all_registers(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_command(random_command());
        send_command('{4'h0, 24'h000000, 16'h0000, 1'b1});
        drain_pulses();
        // key write carries upper bits that the byte register drops
        write_all_registers(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_command('{4'hF, 24'hFFFFFF, 16'hFFFF, 1'b0});
        send_command(random_command());
        drain_pulses();
        // a one-unit symbol halves to zero
        write_register(CFG_SYMBOL, 16'd1);
        send_command(random_command());
        drain_pulses();
        write_register(CFG_SYMBOL, 16'd3);
        send_command(random_command());
        drain_pulses();
    endtask

    // Writes past the register list leave every register as it was
    task automatic test_spare_indexes();
        write_all_registers(16'($urandom), 16'($urandom), 16'($urandom),
                            16'($urandom), 16'($urandom), 16'($urandom));
        write_register(CFG_SPARE_LO, 16'($urandom));
        write_register(CFG_SPARE_HI, 16'($urandom));
        send_command(random_command());
        send_command(random_command());
        drain_pulses();
    endtask

    // Random commands under random register settings, with a pause mid-phase
    task automatic test_random_traffic(input int phases, input int per_phase);
        int pause_at;
        for (int p = 0; p < phases; p++) begin
            write_all_registers(16'($urandom), 16'($urandom), 16'($urandom),
                                16'($urandom), 16'($urandom), 16'($urandom));
            pause_at = $urandom_range(per_phase - 1, 1);
            for (int n = 0; n < per_phase; n++) begin
                if (n == pause_at) drain_pulses();
                send_command(random_command());
            end
            drain_pulses();
        end
    endtask

    // Back-to-back stretch with neither side idling
    task automatic test_steady_stream(input int count);
        sender_idles    = 1'b0;
        receiver_stalls = 1'b0;
        write_all_registers(16'($urandom), 16'($urandom), 16'($urandom),
                            16'($urandom), 16'($urandom), 16'($urandom));
        for (int n = 0; n < count; n++) send_command(random_command());
        drain_pulses();
        sender_idles    = 1'b1;
        receiver_stalls = 1'b1;
    endtask

    // Main sequence
    initial begin
        i_rst_n            <= 1'b0;
        i_cfg_wr_en        <= 1'b0;
        i_cfg_index        <= CFG_KEY_BYTE;
        i_cfg_data         <= 16'h0000;
        cmd_ch.valid       <= 1'b0;
        cmd_ch.cmd_code    <= 4'h0;
        cmd_ch.remote_addr <= 24'h000000;
        cmd_ch.roll_count  <= 16'h0000;
        cmd_ch.short_sync  <= 1'b0;
        cfg_key     = RST_KEY_BYTE;
        cfg_hw_high = RST_HW_HIGH;
        cfg_hw_low  = RST_HW_LOW;
        cfg_sw_high = RST_SW_HIGH;
        cfg_sw_low  = RST_SW_LOW;
        cfg_symbol  = RST_SYMBOL;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_register_extremes();
        test_spare_indexes();
        test_random_traffic(4, 100);
        test_steady_stream(100);

        // final settle: anything arriving now is unexpected
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("covered %0d commands (%0d with short sync), %0d pulses checked,",
                 commands_sent, short_frames, pulses_checked);
        $display("%0d register writes including spare indexes and extremes",
                 register_writes);
        if (error_count == 0 && awaited_pulses.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches, %0d pulses never arrived",
                     error_count, awaited_pulses.size());
            $display("status: fail");
        end
        $finish;
    end

endmodule
